// File: hdl/rmbc_pkg.sv
`timescale 1ns / 1ps

package rmbc_pkg;

   localparam int WORD_BITS = 64;
   localparam int FIELD_BITS = 64;
   localparam logic [FIELD_BITS-1:0] WORD_MAX = {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);

   // raw pitch = width * bytes per pixel, at most 65535 * 4
   localparam int RAW_BITS = 18;
   localparam int DIV_BITS = RAW_BITS + 1;
   localparam int STEPS_PER_STAGE = 6;
   localparam int DIV_STAGES = RAW_BITS / STEPS_PER_STAGE;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_LAYOUT = 3'd1;
   localparam logic [2:0] ST_FORMAT = 3'd2;
   localparam logic [2:0] ST_ALIGN = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_NOMEM = 3'd5;

   typedef struct packed {
      logic [DIV_BITS-1:0] rem;
      logic [RAW_BITS-1:0] dq;
   } div_type;

endpackage

// File: hdl/rmbc_div_steps.sv
`timescale 1ns / 1ps

// A few restoring division steps; quotient bits shift in behind the dividend.
module rmbc_div_steps (
   input  rmbc_pkg::div_type            div_i,
   input  logic [rmbc_pkg::DIV_BITS-1:0] divisor,
   output rmbc_pkg::div_type            div_o
);

   always_comb begin
      logic [rmbc_pkg::DIV_BITS-1:0] r;
      logic q;
      div_o = div_i;
      for (int i = 0; i < rmbc_pkg::STEPS_PER_STAGE; i++) begin
         r = {div_o.rem[rmbc_pkg::DIV_BITS-2:0], div_o.dq[rmbc_pkg::RAW_BITS-1]};
         q = (r >= divisor);
         div_o.rem = q ? r - divisor : r;
         div_o.dq = {div_o.dq[rmbc_pkg::RAW_BITS-2:0], q};
      end
   end

endmodule

// File: hdl/render_memory_budget_check.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    layout, formats, alignment, byte counts
// rsp_      out        rsp_valid/stall    status, pitches, plane sizes, total, left over
//
// Nine register stages; rsp_valid rises when the request reaches the last one.
// One request per cycle is taken while the result side is not stalled; the
// division lanes (three stages of six restoring steps) and the multipliers
// are fully pipelined.
// Synchronous active-high reset clears only the stage valid bits.
// A stalled waiting result holds the whole pipeline; req_stall follows it.

module render_memory_budget_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_available_bytes,
   input  logic [63:0] req_scanout_bytes,
   input  logic [63:0] req_reserved_bytes,
   input  logic [15:0] req_surface_width,
   input  logic [15:0] req_surface_height,
   input  logic [7:0]  req_color_depth_bits,
   input  logic [7:0]  req_zbuffer_bits,
   input  logic [7:0]  req_color_buffers,
   input  logic [63:0] req_row_alignment,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_color_row_pitch,
   output logic [63:0] rsp_color_plane_size,
   output logic [63:0] rsp_depth_row_pitch,
   output logic [63:0] rsp_depth_plane_size,
   output logic [63:0] rsp_used_total,
   output logic [63:0] rsp_left_over
);

   localparam int NSTAGE = 9;
   localparam int LAST = NSTAGE - 1;
   localparam int FB = rmbc_pkg::FIELD_BITS;
   localparam int DB = rmbc_pkg::DIV_BITS;
   localparam int RB = rmbc_pkg::RAW_BITS;

   // Everything one request carries down the pipe; each stage fills its part.
   typedef struct packed {
      logic [2:0]    status;   // early check result, then final
      logic          ovf;
      logic          has_z;
      logic [FB-1:0] avail;
      logic [FB-1:0] scan;
      logic [FB-1:0] resv;
      logic [15:0]   height;
      logic [7:0]    nbuf;
      logic [FB-1:0] align;
      logic [DB-1:0] divisor;
      rmbc_pkg::div_type c_div;
      rmbc_pkg::div_type z_div;
      logic [FB-1:0] cp;
      logic [FB-1:0] dp;
      logic [FB-1:0] cs;
      logic [FB-1:0] ds;
      logic [FB-1:0] ct;
      logic [FB:0]   sr;
      logic [FB-1:0] tot;
      logic [FB-1:0] left;
   } item_type;

   item_type pipe_ff [NSTAGE];
   item_type pipe_in [NSTAGE];
   logic     valid_ff [NSTAGE];
   logic     advance;

   rmbc_pkg::div_type c_div_out [rmbc_pkg::DIV_STAGES];
   rmbc_pkg::div_type z_div_out [rmbc_pkg::DIV_STAGES];

   function automatic logic fmt_ok(input logic [7:0] bpp);
      return bpp == 8'd8 || bpp == 8'd16 || bpp == 8'd24 || bpp == 8'd32;
   endfunction

   // whole pipe moves together; a bubble at the end frees it
   assign advance = !valid_ff[LAST] || !rsp_stall;
   assign req_stall = !advance;

   genvar g;
   generate
      for (g = 0; g < rmbc_pkg::DIV_STAGES; g++) begin : g_div
         rmbc_div_steps u_c (
            .div_i   (pipe_ff[g].c_div),
            .divisor (pipe_ff[g].divisor),
            .div_o   (c_div_out[g])
         );
         rmbc_div_steps u_z (
            .div_i   (pipe_ff[g].z_div),
            .divisor (pipe_ff[g].divisor),
            .div_o   (z_div_out[g])
         );
      end
   endgenerate

   always_comb begin
      logic [FB-1:0] avail_m;
      logic [FB-1:0] scan_m;
      logic [FB-1:0] resv_m;
      logic [FB-1:0] align_m;
      logic [RB:0]   raw_c;
      logic [RB:0]   raw_z;
      logic [FB:0]   up_c;
      logic [FB:0]   up_z;
      logic          has_z;
      logic [DB+FB-1:0] pp_c;
      logic [DB+FB-1:0] pp_z;
      logic [FB+15:0] sz_c;
      logic [FB+15:0] sz_z;
      logic [FB+7:0]  ctp;
      logic [FB+8:0]  sum;

      // stage 0: masking, early checks, raw pitches, divider setup
      avail_m = req_available_bytes & rmbc_pkg::WORD_MAX;
      scan_m  = req_scanout_bytes & rmbc_pkg::WORD_MAX;
      resv_m  = req_reserved_bytes & rmbc_pkg::WORD_MAX;
      align_m = req_row_alignment & rmbc_pkg::WORD_MAX;
      has_z   = (req_zbuffer_bits != 8'd0);
      pipe_in[0] = '0;
      if (avail_m == '0 || scan_m == '0 || req_surface_width == 16'd0 ||
          req_surface_height == 16'd0 || req_color_buffers == 8'd0) begin
         pipe_in[0].status = rmbc_pkg::ST_LAYOUT;
      end else if (!fmt_ok(req_color_depth_bits) || (has_z && !fmt_ok(req_zbuffer_bits))) begin
         pipe_in[0].status = rmbc_pkg::ST_FORMAT;
      end else if (align_m == '0) begin
         pipe_in[0].status = rmbc_pkg::ST_ALIGN;
      end else begin
         pipe_in[0].status = rmbc_pkg::ST_OK;
      end
      raw_c = (RB+1)'(req_surface_width) * (RB+1)'(req_color_depth_bits[5:3]);
      raw_z = (RB+1)'(req_surface_width) * (RB+1)'(req_zbuffer_bits[5:3]);
      up_c = (FB+1)'(align_m) + (FB+1)'(raw_c) - (FB+1)'(1);
      up_z = (FB+1)'(align_m) + (FB+1)'(raw_z) - (FB+1)'(1);
      pipe_in[0].ovf = (up_c > (FB+1)'(rmbc_pkg::WORD_MAX)) ||
                       (has_z && up_z > (FB+1)'(rmbc_pkg::WORD_MAX));
      pipe_in[0].has_z  = has_z;
      pipe_in[0].avail  = avail_m;
      pipe_in[0].scan   = scan_m;
      pipe_in[0].resv   = resv_m;
      pipe_in[0].height = req_surface_height;
      pipe_in[0].nbuf   = req_color_buffers;
      pipe_in[0].align  = align_m;
      // alignment beyond any raw pitch: clamp, quotient is then zero anyway
      pipe_in[0].divisor = (align_m[FB-1:RB] != '0) ? {1'b1, {RB{1'b0}}}
                                                    : {1'b0, align_m[RB-1:0]};
      // ceil(raw / a) = floor((raw - 1) / a) + 1, raw is nonzero wherever the result is used
      pipe_in[0].c_div.rem = '0;
      pipe_in[0].c_div.dq  = RB'(raw_c - (RB+1)'(1));
      pipe_in[0].z_div.rem = '0;
      pipe_in[0].z_div.dq  = RB'(raw_z - (RB+1)'(1));

      // stages 1..3: division
      for (int s = 1; s <= rmbc_pkg::DIV_STAGES; s++) begin
         pipe_in[s] = pipe_ff[s-1];
         pipe_in[s].c_div = c_div_out[s-1];
         pipe_in[s].z_div = z_div_out[s-1];
      end

      // stage 4: pitch = (q + 1) * alignment, never above the rounded-up sum
      pipe_in[4] = pipe_ff[3];
      pp_c = (DB+FB)'({1'b0, pipe_ff[3].c_div.dq} + DB'(1)) * (DB+FB)'(pipe_ff[3].align);
      pp_z = (DB+FB)'({1'b0, pipe_ff[3].z_div.dq} + DB'(1)) * (DB+FB)'(pipe_ff[3].align);
      pipe_in[4].cp = pp_c[FB-1:0];
      pipe_in[4].dp = pipe_ff[3].has_z ? pp_z[FB-1:0] : '0;

      // stage 5: plane sizes
      pipe_in[5] = pipe_ff[4];
      sz_c = (FB+16)'(pipe_ff[4].cp) * (FB+16)'(pipe_ff[4].height);
      sz_z = (FB+16)'(pipe_ff[4].dp) * (FB+16)'(pipe_ff[4].height);
      pipe_in[5].cs = sz_c[FB-1:0];
      pipe_in[5].ds = sz_z[FB-1:0];
      pipe_in[5].ovf = pipe_ff[4].ovf || (sz_c > (FB+16)'(rmbc_pkg::WORD_MAX)) ||
                       (sz_z > (FB+16)'(rmbc_pkg::WORD_MAX));

      // stage 6: all color buffers, scanout plus reserved
      pipe_in[6] = pipe_ff[5];
      ctp = (FB+8)'(pipe_ff[5].cs) * (FB+8)'(pipe_ff[5].nbuf);
      pipe_in[6].ct = ctp[FB-1:0];
      pipe_in[6].ovf = pipe_ff[5].ovf || (ctp > (FB+8)'(rmbc_pkg::WORD_MAX));
      pipe_in[6].sr = (FB+1)'(pipe_ff[5].scan) + (FB+1)'(pipe_ff[5].resv);

      // stage 7: total; partial sums only grow, so one check covers the chain
      pipe_in[7] = pipe_ff[6];
      sum = (FB+9)'(pipe_ff[6].sr) + (FB+9)'(pipe_ff[6].ct) + (FB+9)'(pipe_ff[6].ds);
      pipe_in[7].tot = sum[FB-1:0];
      pipe_in[7].ovf = pipe_ff[6].ovf || (sum > (FB+9)'(rmbc_pkg::WORD_MAX));

      // stage 8: final status, zero everything on failure
      pipe_in[8] = pipe_ff[7];
      pipe_in[8].left = pipe_ff[7].avail - pipe_ff[7].tot;
      if (pipe_ff[7].status == rmbc_pkg::ST_OK) begin
         if (pipe_ff[7].ovf) begin
            pipe_in[8].status = rmbc_pkg::ST_OVERFLOW;
         end else if (pipe_ff[7].tot > pipe_ff[7].avail) begin
            pipe_in[8].status = rmbc_pkg::ST_NOMEM;
         end
      end
      if (pipe_in[8].status != rmbc_pkg::ST_OK) begin
         pipe_in[8].cp   = '0;
         pipe_in[8].cs   = '0;
         pipe_in[8].dp   = '0;
         pipe_in[8].ds   = '0;
         pipe_in[8].tot  = '0;
         pipe_in[8].left = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTAGE; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s < NSTAGE; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NSTAGE; s++) pipe_ff[s] <= pipe_in[s];
      end
   end

   assign rsp_valid            = valid_ff[LAST];
   assign rsp_status           = pipe_ff[LAST].status;
   assign rsp_color_row_pitch  = pipe_ff[LAST].cp;
   assign rsp_color_plane_size = pipe_ff[LAST].cs;
   assign rsp_depth_row_pitch  = pipe_ff[LAST].dp;
   assign rsp_depth_plane_size = pipe_ff[LAST].ds;
   assign rsp_used_total       = pipe_ff[LAST].tot;
   assign rsp_left_over        = pipe_ff[LAST].left;

endmodule

// File: verif/tb_render_memory_budget_check.sv
`timescale 1ns / 1ps

module tb_render_memory_budget_check;

   // one request as the sender sees it
   typedef struct {
      logic [63:0] avail;
      logic [63:0] scan;
      logic [63:0] resv;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  cbits;
      logic [7:0]  zbits;
      logic [7:0]  nbuf;
      logic [63:0] align;
   } budget_req_type;

   // one expected answer
   typedef struct {
      logic [2:0]  status;
      logic [63:0] cpitch;
      logic [63:0] csize;
      logic [63:0] dpitch;
      logic [63:0] dsize;
      logic [63:0] total;
      logic [63:0] left;
   } budget_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_available_bytes;
   logic [63:0] req_scanout_bytes;
   logic [63:0] req_reserved_bytes;
   logic [15:0] req_surface_width;
   logic [15:0] req_surface_height;
   logic [7:0]  req_color_depth_bits;
   logic [7:0]  req_zbuffer_bits;
   logic [7:0]  req_color_buffers;
   logic [63:0] req_row_alignment;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_color_row_pitch;
   logic [63:0] rsp_color_plane_size;
   logic [63:0] rsp_depth_row_pitch;
   logic [63:0] rsp_depth_plane_size;
   logic [63:0] rsp_used_total;
   logic [63:0] rsp_left_over;

   render_memory_budget_check DUT (.*);

   budget_req_type pending_reqs[$];
   budget_rsp_type expected_budgets[$];
   int          mismatch_count = 0;
   bit          stim_done = 0;
   bit          hold_sender = 0;   // pause request transfers until the pipe drains
   int          send_gap = 0;
   int          recv_gap = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // most often no gap at all, otherwise mostly short ones, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // Predictor: checked add/multiply at WORD_BITS, then the fixed
   // order of checks. Wider math in 128 bits catches overflow.
   // ---------------------------------------------------------------
   function automatic bit bpp_supported(logic [7:0] b);
      return b == 8'd8 || b == 8'd16 || b == 8'd24 || b == 8'd32;
   endfunction

   function automatic bit word_mul(logic [63:0] a, logic [63:0] b, output logic [63:0] r);
      logic [127:0] p;
      p = a * b;
      r = p[63:0] & rmbc_pkg::WORD_MAX;
      return p <= {64'd0, rmbc_pkg::WORD_MAX};
   endfunction

   function automatic bit word_add(logic [63:0] a, logic [63:0] b, output logic [63:0] r);
      logic [127:0] s;
      s = {64'd0, a} + {64'd0, b};
      r = s[63:0] & rmbc_pkg::WORD_MAX;
      return s <= {64'd0, rmbc_pkg::WORD_MAX};
   endfunction

   function automatic bit surface_plane(logic [63:0] w, logic [63:0] h, logic [7:0] bpp,
                                        logic [63:0] align, output logic [63:0] pitch,
                                        output logic [63:0] size);
      logic [63:0]  raw;
      logic [127:0] up;
      pitch = 0;
      size = 0;
      if (!word_mul(w, {56'd0, bpp} / 64'd8, raw)) return 0;
      up = {64'd0, raw} + {64'd0, align} - 128'd1;
      if (up > {64'd0, rmbc_pkg::WORD_MAX}) return 0;
      pitch = (up[63:0] / align) * align;
      return word_mul(pitch, h, size);
   endfunction

   function automatic budget_rsp_type predict_budget(budget_req_type q);
      budget_rsp_type e;
      logic [63:0] av, sc, rs, al, ct, tot;
      logic [63:0] w, h, nb;
      bit ok;
      av = q.avail & rmbc_pkg::WORD_MAX;
      sc = q.scan & rmbc_pkg::WORD_MAX;
      rs = q.resv & rmbc_pkg::WORD_MAX;
      al = q.align & rmbc_pkg::WORD_MAX;
      w = {48'd0, q.w};
      h = {48'd0, q.h};
      nb = {56'd0, q.nbuf};
      e = '{default: '0};
      e.status = rmbc_pkg::ST_OK;
      ct = 0;
      tot = 0;
      if (av == 0 || sc == 0 || w == 0 || h == 0 || nb == 0)
         e.status = rmbc_pkg::ST_LAYOUT;
      else if (!bpp_supported(q.cbits) || (q.zbits != 0 && !bpp_supported(q.zbits)))
         e.status = rmbc_pkg::ST_FORMAT;
      else if (al == 0)
         e.status = rmbc_pkg::ST_ALIGN;
      else begin
         ok = surface_plane(w, h, q.cbits, al, e.cpitch, e.csize);
         if (ok) ok = word_mul(e.csize, nb, ct);
         if (ok && q.zbits != 0) ok = surface_plane(w, h, q.zbits, al, e.dpitch, e.dsize);
         if (ok) ok = word_add(sc, rs, tot);
         if (ok) ok = word_add(tot, ct, tot);
         if (ok) ok = word_add(tot, e.dsize, tot);
         if (!ok) e.status = rmbc_pkg::ST_OVERFLOW;
         else if (tot > av) e.status = rmbc_pkg::ST_NOMEM;
         else begin
            e.total = tot;
            e.left = av - tot;
         end
      end
      if (e.status != rmbc_pkg::ST_OK) e = '{status: e.status, default: '0};
      return e;
   endfunction

   // ---------------------------------------------------------------
   // Driver: presents the head of the queue; payload stays put while
   // stalled, and valid is only dropped for a gap, an empty queue or a held sender.
   // ---------------------------------------------------------------
   task automatic drive_req(budget_req_type q);
      req_available_bytes  <= q.avail;
      req_scanout_bytes    <= q.scan;
      req_reserved_bytes   <= q.resv;
      req_surface_width    <= q.w;
      req_surface_height   <= q.h;
      req_color_depth_bits <= q.cbits;
      req_zbuffer_bits     <= q.zbits;
      req_color_buffers    <= q.nbuf;
      req_row_alignment    <= q.align;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            // transfer happened at this edge
            expected_budgets.push_back(predict_budget(pending_reqs.pop_front()));
            send_gap = pick_gap();
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer as is
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (pending_reqs.size() > 0 && !hold_sender) begin
            req_valid <= 1;
            drive_req(pending_reqs[0]);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compares each result transfer against the oldest
   // expectation, and drives random stalls on the result side.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      budget_rsp_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_budgets.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer, status %0d", rsp_status);
            end else begin
               e = expected_budgets.pop_front();
               if (rsp_status !== e.status || rsp_color_row_pitch !== e.cpitch ||
                   rsp_color_plane_size !== e.csize || rsp_depth_row_pitch !== e.dpitch ||
                   rsp_depth_plane_size !== e.dsize || rsp_used_total !== e.total ||
                   rsp_left_over !== e.left) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: exp st=%0d cp=%0h cs=%0h dp=%0h ds=%0h tot=%0h left=%0h",
                              e.status, e.cpitch, e.csize, e.dpitch, e.dsize, e.total,
                              e.left);
                     $display("          got st=%0d cp=%0h cs=%0h dp=%0h ds=%0h tot=%0h left=%0h",
                              rsp_status, rsp_color_row_pitch, rsp_color_plane_size,
                              rsp_depth_row_pitch, rsp_depth_plane_size, rsp_used_total,
                              rsp_left_over);
                  end
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic logic [7:0] pick_bpp(bit allow_zero);
      logic [7:0] t[5] = '{8'd8, 8'd16, 8'd24, 8'd32, 8'd0};
      if ($urandom_range(0, 19) == 0) return 8'($urandom);
      return t[$urandom_range(0, allow_zero ? 4 : 3)];
   endfunction

   function automatic logic [63:0] rand64();
      return {32'($urandom), 32'($urandom)};
   endfunction

   // wide spread of magnitudes so both fitting and overflowing totals occur
   function automatic logic [63:0] rand_mag();
      int sh;
      sh = $urandom_range(0, 63);
      return rand64() >> sh;
   endfunction

   function automatic budget_req_type rand_req();
      budget_req_type q;
      int mode;
      mode = $urandom_range(0, 9);
      q.w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2048));
      q.h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2048));
      q.cbits = pick_bpp(0);
      q.zbits = pick_bpp(1);
      q.nbuf = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
      q.align = ($urandom_range(0, 3) == 0) ? rand_mag() : 64'(1 << $urandom_range(0, 12));
      if ($urandom_range(0, 19) == 0) q.align = 64'($urandom_range(1, 1000));
      q.scan = ($urandom_range(0, 3) == 0) ? rand_mag() : 64'($urandom_range(1, 1 << 24));
      q.resv = ($urandom_range(0, 3) == 0) ? rand_mag() : 64'($urandom_range(0, 1 << 20));
      q.avail = ($urandom_range(0, 2) == 0) ? rand_mag() : rand64() >> $urandom_range(20, 40);
      // a few broken layouts
      if (mode == 0) begin
         case ($urandom_range(0, 5))
            0: q.avail = 0;
            1: q.scan = 0;
            2: q.w = 0;
            3: q.h = 0;
            4: q.nbuf = 0;
            default: q.align = 0;
         endcase
      end
      return q;
   endfunction

   function automatic budget_req_type mk_req(logic [63:0] av, logic [63:0] sc,
                                             logic [63:0] rs, logic [15:0] w,
                                             logic [15:0] h, logic [7:0] cb,
                                             logic [7:0] zb, logic [7:0] nb,
                                             logic [63:0] al);
      budget_req_type q;
      q = '{av, sc, rs, w, h, cb, zb, nb, al};
      return q;
   endfunction

   localparam logic [63:0] ALL1 = '1;

   initial begin
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      req_available_bytes = 0;
      req_scanout_bytes = 0;
      req_reserved_bytes = 0;
      req_surface_width = 0;
      req_surface_height = 0;
      req_color_depth_bits = 0;
      req_zbuffer_bits = 0;
      req_color_buffers = 0;
      req_row_alignment = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: each check in order, format and alignment corners
      pending_reqs.push_back(mk_req(64'h100000, 4096, 0, 640, 480, 16, 16, 2, 64));
      pending_reqs.push_back(mk_req(0, 4096, 0, 640, 480, 16, 0, 2, 64));
      pending_reqs.push_back(mk_req(ALL1, 0, 0, 640, 480, 16, 0, 2, 64));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 0, 480, 16, 0, 2, 64));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 640, 0, 16, 0, 2, 64));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 640, 480, 16, 0, 0, 64));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 640, 480, 12, 0, 1, 64));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 640, 480, 32, 255, 1, 64));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 640, 480, 255, 0, 1, 0));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 640, 480, 24, 24, 1, 0));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 65535, 65535, 32, 32, 255, 1));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 65535, 65535, 8, 8, 1, ALL1));
      pending_reqs.push_back(mk_req(ALL1, ALL1, ALL1, 1, 1, 8, 0, 1, 1));
      pending_reqs.push_back(mk_req(ALL1, ALL1, 0, 1, 1, 8, 0, 1, 1));
      pending_reqs.push_back(mk_req(ALL1, 1, ALL1 - 2, 1, 1, 8, 0, 1, 1));
      pending_reqs.push_back(mk_req(100, 50, 0, 10, 10, 8, 0, 1, 1));
      pending_reqs.push_back(mk_req(150, 50, 0, 10, 10, 8, 0, 1, 1));
      pending_reqs.push_back(mk_req(ALL1, 7, 3, 333, 17, 24, 16, 3, 1000));
      pending_reqs.push_back(mk_req(ALL1, 7, 3, 1, 1, 8, 32, 1, 64'h8000_0000_0000_0000));
      pending_reqs.push_back(mk_req(ALL1, 1, 0, 3, 5, 32, 8, 1, 7));

      // random part, with one full drain partway through
      for (int i = 0; i < 1330; i++) begin
         pending_reqs.push_back(rand_req());
         if (i == 600) begin
            wait (pending_reqs.size() == 0);
            hold_sender = 1;
            wait (expected_budgets.size() == 0);
            hold_sender = 0;
         end
      end
      wait (pending_reqs.size() == 0);
      stim_done = 1;
   end

   // end of run: drain, let the pipe settle, then report
   initial begin
      wait (stim_done);
      wait (expected_budgets.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog well beyond the slowest correct run
   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: render_memory_budget_check.f
hdl/rmbc_pkg.sv
hdl/rmbc_div_steps.sv
hdl/render_memory_budget_check.sv
verif/tb_render_memory_budget_check.sv
